// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_DEF(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/vgrd_pkg.sv =====
package vgrd_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned PosW   = 31;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  // FORMAT field is the ninth (index 8), POS the second, ALT the fifth
  localparam logic [3:0] FLD_POS    = 4'd1;
  localparam logic [3:0] FLD_ALT    = 4'd4;
  localparam logic [3:0] FLD_FORMAT = 4'd8;

  // configuration register indexes
  localparam logic CFG_SAMPLE_COUNT = 1'b0;
  localparam logic CFG_DOSAGE_MODE  = 1'b1;

  typedef enum logic {
    KIND_CALL  = 1'b0,
    KIND_ERROR = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_FEW_FIELDS  = 4'd1,
    ERR_NOT_GT      = 4'd2,
    ERR_POS_EMPTY   = 4'd3,
    ERR_POS_DIGIT   = 4'd4,
    ERR_POS_OVF     = 4'd5,
    ERR_MULTI_ALT   = 4'd6,
    ERR_TRUNCATED   = 4'd7,
    ERR_SEPARATOR   = 4'd8,
    ERR_BAD_ALLELE  = 4'd9,
    ERR_UNPHASED    = 4'd10
  } err_code_e;

  typedef struct packed {
    kind_e              kind;
    logic [PosW-1:0]    record_position;
    logic [CountW-1:0]  sample_number;
    logic signed [4:0]  first_allele;
    logic signed [4:0]  second_allele;
    logic signed [5:0]  allele_dosage;
    logic               is_phased;
    logic               last_in_record;
    err_code_e          error_code;
  } vgrd_result_t;

endpackage

// ===== hw/rtl/vcf_gt_record_decoder_top.sv =====
// GT-only VCF body decoder. Takes one text byte per beat and, at full rate, accepts a
// byte every cycle; each byte is held in the input register and parsed in one pass into
// the result register, so a genotype or error beat is presented from the result register
// after the input register. Throughput drops only while the result register is held by
// m_axis_tready low. Each call gives both alleles (-1 for '.' or '-'), the dosage and
// the record POS; the first error gives one error beat and the decoder stays silent until
// reset. Write sample_count and dosage_mode only while no bytes are in flight.
module vcf_gt_record_decoder_top import vgrd_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_data
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [30:0] record_position, [46:31] sample_number, [51:47] first_allele,
  // [56:52] second_allele, [62:57] allele_dosage, [63] is_phased,
  // [67:64] error_code, [71:68] zero
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast,   // last_in_record
  output logic        m_axis_tuser,   // result_kind
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_eod_q;
  logic              advance;
  logic              out_free;
  logic              res_valid;
  vgrd_result_t      res;
  vgrd_result_t      out_res;
  logic [CountW-1:0] sample_count_q;
  logic              dosage_mode_q;

  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      sample_count_q <= CountW'(1);
      dosage_mode_q  <= 1'b1;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i;
          CFG_DOSAGE_MODE:  dosage_mode_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eod_q  <= s_axis_tlast;
    end
  end

  vgrd_parser #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .byte_i         (in_byte_q),
    .eod_i          (in_eod_q),
    .sample_count_i (sample_count_q),
    .dosage_mode_i  (dosage_mode_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  vgrd_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (res_valid),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tready (m_axis_tready),
    .valid_o       (m_axis_tvalid),
    .res_o         (out_res)
  );

  assign m_axis_tdata = {4'b0, out_res.error_code, out_res.is_phased, out_res.allele_dosage,
                         out_res.second_allele, out_res.first_allele,
                         out_res.sample_number, out_res.record_position};
  assign m_axis_tlast = out_res.last_in_record;
  assign m_axis_tuser = out_res.kind;

endmodule

// ===== hw/rtl/vgrd_parser.sv =====
`include "assert_macros.svh"

module vgrd_parser import vgrd_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 65535
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              eod_i,
  input  logic [CountW-1:0] sample_count_i,
  input  logic              dosage_mode_i,
  output logic              res_valid_o,
  output vgrd_result_t      res_o
);

  localparam int unsigned MaxClamp = (MAX_SAMPLES > 65535) ? 65535 : MAX_SAMPLES;
  localparam logic [CountW-1:0] MaxCount = CountW'(MaxClamp);

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_FIELDS,
    PH_SAMPLES,
    PH_END_CR,
    PH_END_LF
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [3:0]         fc_q, fc_d, fc_c;
  logic [1:0]         fl_q, fl_d, fl_c;
  logic [PosW-1:0]    pos_q, pos_d, pos_c;
  logic [CountW-1:0]  sc_q, sc_d;
  logic [1:0]         bis_q, bis_d;
  logic signed [4:0]  held_q, held_d;
  logic               ph_q, ph_d;
  logic               err_q, err_d;

  logic               run_fields;
  logic               err_hit;
  err_code_e          err_code;
  logic               emit;
  logic               emit_last;
  logic               is_eol;
  logic               is_digit;
  logic               allele_ok;
  logic signed [4:0]  allele;
  logic [PosW+3:0]    acc;
  logic [CountW-1:0]  cnt_nz;
  logic [CountW-1:0]  eff_count;
  logic               last_call;
  logic signed [5:0]  dosage;

  assign is_eol   = (byte_i inside {CH_CR, CH_LF});
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign allele_ok = is_digit || (byte_i inside {CH_DOT, CH_DASH});
  assign allele    = is_digit ? $signed({1'b0, byte_i[3:0]}) : 5'sh1F;

  // pos * 10 + digit, widened so overflow past 31 bits is visible; POS digits
  // only arrive inside a record, where the accumulator is already current
  assign acc = ({4'b0, pos_q} << 3) + ({4'b0, pos_q} << 1) + {{(PosW){1'b0}}, byte_i[3:0]};

  assign cnt_nz    = (sample_count_i == '0) ? CountW'(1) : sample_count_i;
  assign eff_count = (cnt_nz > MaxCount) ? MaxCount : cnt_nz;
  assign last_call = ({1'b0, sc_q} + (CountW+1)'(1)) >= {1'b0, eff_count};

  assign dosage = (held_q < 0 || allele < 0) ? -6'sd1
                : ({held_q[4], held_q} + {allele[4], allele});

  always_comb begin
    phase_d    = phase_q;
    fc_d       = fc_q;
    fl_d       = fl_q;
    pos_d      = pos_q;
    sc_d       = sc_q;
    bis_d      = bis_q;
    held_d     = held_q;
    ph_d       = ph_q;
    err_d      = err_q;
    fc_c       = fc_q;
    fl_c       = fl_q;
    pos_c      = pos_q;
    run_fields = 1'b0;
    err_hit    = 1'b0;
    err_code   = ERR_NONE;
    emit       = 1'b0;
    emit_last  = 1'b0;

    if (step_i && !err_q) begin
      case (phase_q)
        PH_SKIP: begin
          if (!is_eol) begin
            phase_d    = PH_FIELDS;
            fc_c       = '0;
            fl_c       = '0;
            pos_c      = '0;
            run_fields = 1'b1;
          end
        end
        PH_FIELDS: begin
          run_fields = 1'b1;
        end
        PH_SAMPLES: begin
          case (bis_q)
            2'd0: begin
              if (!allele_ok) begin
                err_hit = 1'b1; err_code = ERR_BAD_ALLELE;
              end else if (eod_i) begin
                err_hit = 1'b1; err_code = ERR_TRUNCATED;
              end else begin
                held_d = allele;
                bis_d  = 2'd1;
              end
            end
            2'd1: begin
              if (!(byte_i inside {CH_PIPE, CH_SLASH})) begin
                err_hit = 1'b1; err_code = ERR_SEPARATOR;
              end else if (byte_i == CH_SLASH && !dosage_mode_i) begin
                err_hit = 1'b1; err_code = ERR_UNPHASED;
              end else if (eod_i) begin
                err_hit = 1'b1; err_code = ERR_TRUNCATED;
              end else begin
                ph_d  = (byte_i == CH_PIPE);
                bis_d = 2'd2;
              end
            end
            2'd2: begin
              if (!allele_ok) begin
                err_hit = 1'b1; err_code = ERR_BAD_ALLELE;
              end else if (last_call) begin
                emit      = 1'b1;
                emit_last = 1'b1;
                phase_d   = PH_END_CR;
              end else if (eod_i) begin
                err_hit = 1'b1; err_code = ERR_TRUNCATED;
              end else begin
                emit  = 1'b1;
                bis_d = 2'd3;
              end
            end
            default: begin
              if (byte_i != CH_TAB) begin
                err_hit = 1'b1; err_code = ERR_SEPARATOR;
              end else if (eod_i) begin
                err_hit = 1'b1; err_code = ERR_TRUNCATED;
              end else begin
                sc_d  = sc_q + CountW'(1);
                bis_d = 2'd0;
              end
            end
          endcase
        end
        PH_END_CR: begin
          if (byte_i == CH_CR) begin
            phase_d = PH_END_LF;
          end else if (byte_i == CH_LF) begin
            phase_d = PH_SKIP;
          end else begin
            err_hit = 1'b1; err_code = ERR_SEPARATOR;
          end
        end
        PH_END_LF: begin
          if (byte_i == CH_LF) begin
            phase_d = PH_SKIP;
          end else begin
            err_hit = 1'b1; err_code = ERR_SEPARATOR;
          end
        end
        default: begin
          phase_d = PH_SKIP;
        end
      endcase

      if (run_fields) begin
        fc_d  = fc_c;
        fl_d  = fl_c;
        pos_d = pos_c;
        if (byte_i == CH_TAB) begin
          if (fc_c == FLD_POS && fl_c == 2'd0) begin
            err_hit = 1'b1; err_code = ERR_POS_EMPTY;
          end else if (fc_c == FLD_FORMAT) begin
            if (fl_c != 2'd2) begin
              err_hit = 1'b1; err_code = ERR_NOT_GT;
            end else if (eod_i) begin
              err_hit = 1'b1; err_code = ERR_TRUNCATED;
            end else begin
              phase_d = PH_SAMPLES;
              sc_d    = '0;
              bis_d   = 2'd0;
            end
          end else if (eod_i) begin
            err_hit = 1'b1; err_code = ERR_FEW_FIELDS;
          end else begin
            fc_d = fc_c + 4'd1;
            fl_d = '0;
            if (fc_c == 4'd0) pos_d = '0;
          end
        end else if (is_eol) begin
          err_hit = 1'b1; err_code = ERR_FEW_FIELDS;
        end else begin
          if (fc_c == FLD_POS) begin
            if (!is_digit) begin
              err_hit = 1'b1; err_code = ERR_POS_DIGIT;
            end else if (|acc[PosW+3:PosW]) begin
              err_hit = 1'b1; err_code = ERR_POS_OVF;
            end else begin
              pos_d = acc[PosW-1:0];
            end
          end else if (fc_c == FLD_ALT) begin
            if (dosage_mode_i && byte_i == CH_COMMA) begin
              err_hit = 1'b1; err_code = ERR_MULTI_ALT;
            end
          end else if (fc_c == FLD_FORMAT) begin
            if (fl_c >= 2'd2) begin
              err_hit = 1'b1; err_code = ERR_NOT_GT;
            end else if (byte_i != ((fl_c == 2'd0) ? CH_G : CH_T)) begin
              err_hit = 1'b1; err_code = ERR_NOT_GT;
            end
          end
          if (!err_hit) begin
            if (fl_c != 2'd3) fl_d = fl_c + 2'd1;
            if (eod_i) begin
              err_hit = 1'b1; err_code = ERR_FEW_FIELDS;
            end
          end
        end
      end

      if (eod_i) phase_d = PH_SKIP;
      if (err_hit) err_d = 1'b1;
    end
  end

  always_comb begin
    res_o       = '0;
    res_valid_o = err_hit || emit;
    if (err_hit) begin
      res_o.kind       = KIND_ERROR;
      res_o.error_code = err_code;
    end else begin
      res_o.kind            = KIND_CALL;
      res_o.record_position = pos_q;
      res_o.sample_number   = sc_q;
      res_o.first_allele    = held_q;
      res_o.second_allele   = allele;
      res_o.allele_dosage   = dosage;
      res_o.is_phased       = ph_q;
      res_o.last_in_record  = emit_last;
      res_o.error_code      = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      fc_q    <= '0;
      fl_q    <= '0;
      pos_q   <= '0;
      sc_q    <= '0;
      bis_q   <= '0;
      held_q  <= '0;
      ph_q    <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fc_q    <= fc_d;
      fl_q    <= fl_d;
      pos_q   <= pos_d;
      sc_q    <= sc_d;
      bis_q   <= bis_d;
      held_q  <= held_d;
      ph_q    <= ph_d;
      err_q   <= err_d;
    end
  end

  `ASSERT_DEF(a_silent_after_err, err_q |-> !res_valid_o, "result after sticky error")
  `ASSERT_DEF(a_kind_code, res_valid_o |-> ((res_o.kind == KIND_ERROR) == (res_o.error_code != ERR_NONE)), "error code does not match result kind")
  `ASSERT_DEF(a_call_src, (res_valid_o && res_o.kind == KIND_CALL) |-> (phase_q == PH_SAMPLES && bis_q == 2'd2), "call emitted outside second allele byte")
  `ASSERT_DEF(a_err_sticks, err_q |=> err_q, "error flag cleared without reset")

endmodule

// ===== hw/rtl/vgrd_out_stage.sv =====
`include "assert_macros.svh"

module vgrd_out_stage import vgrd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  vgrd_result_t res_i,
  output logic         free_o,
  input  logic         m_axis_tready,
  output logic         valid_o,
  output vgrd_result_t res_o
);

  logic         valid_q, valid_d;
  vgrd_result_t res_q;

  // slot can take a new result when empty or draining this cycle
  assign free_o  = !valid_q || m_axis_tready;
  assign valid_d = load_i || (valid_q && !m_axis_tready);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  `ASSERT_DEF(a_no_overwrite, load_i |-> (!valid_q || m_axis_tready), "pending result overwritten")

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import vgrd_pkg::*;

  localparam int   SETTLE_CYCLES    = 6;
  localparam int   CYCLE_LIMIT      = 2_000_000;
  localparam int   RANDOM_BYTES     = 250;

  typedef enum logic [2:0] {
    ST_BETWEEN,
    ST_FIELDS,
    ST_CALLS,
    ST_AFTER_CALLS,
    ST_AWAIT_LF
  } parse_state_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  vcf_gt_record_decoder_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder shadow: configuration and parse state
  logic [15:0]        model_count = 16'd1;
  logic               model_dosage = 1'b1;
  parse_state_e       st = ST_BETWEEN;
  logic [3:0]         fld = '0;
  logic [1:0]         flen = '0;
  logic [30:0]        pos_acc = '0;
  logic [15:0]        smp = '0;
  logic [1:0]         bis = '0;
  logic signed [4:0]  held_a = '0;
  logic               held_ph = 1'b0;
  logic               err_seen = 1'b0;

  vgrd_result_t decoded_q[$];
  logic [8:0]   line_q[$];   // {end_of_data, byte}

  int  mismatch_count = 0;
  int  bytes_sent = 0;
  int  cycle_count = 0;
  int  hold_off_cycles = 0;
  bit  idling_on = 1'b0;

  function automatic int allele_of(logic [7:0] b);
    if (b == CH_DOT || b == CH_DASH) return -1;
    if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
    return -2;
  endfunction

  function automatic void flag_error(err_code_e code);
    vgrd_result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    decoded_q.push_back(r);
    err_seen = 1'b1;
  endfunction

  function automatic void take_call(int second, bit closes);
    vgrd_result_t r;
    int first;
    int dos;
    first = int'(held_a);
    dos = (first < 0 || second < 0) ? -1 : first + second;
    r = '0;
    r.kind = KIND_CALL;
    r.record_position = pos_acc;
    r.sample_number = smp;
    r.first_allele = held_a;
    r.second_allele = second[4:0];
    r.allele_dosage = dos[5:0];
    r.is_phased = held_ph;
    r.last_in_record = closes;
    r.error_code = ERR_NONE;
    decoded_q.push_back(r);
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eod);
    int         a;
    int         eff;
    bit         closes;
    logic [35:0] acc;
    if (err_seen) return;
    eff = (model_count == 16'd0) ? 1 : int'(model_count);
    closes = (int'(smp) + 1) >= eff;
    if (st == ST_BETWEEN && b != CH_CR && b != CH_LF) begin
      st = ST_FIELDS;
      fld = '0;
      flen = '0;
      pos_acc = '0;
    end
    case (st)
      ST_FIELDS: begin
        if (b == CH_TAB) begin
          if (fld == FLD_POS && flen == 2'd0) flag_error(ERR_POS_EMPTY);
          else if (fld == FLD_FORMAT) begin
            if (flen != 2'd2) flag_error(ERR_NOT_GT);
            else if (eod) flag_error(ERR_TRUNCATED);
            else begin
              st = ST_CALLS;
              smp = '0;
              bis = '0;
            end
          end else if (eod) flag_error(ERR_FEW_FIELDS);
          else begin
            fld = fld + 4'd1;
            flen = '0;
            if (fld == FLD_POS) pos_acc = '0;
          end
        end else if (b == CH_CR || b == CH_LF) begin
          flag_error(ERR_FEW_FIELDS);
        end else begin
          acc = {5'b0, pos_acc} * 36'd10 + b - CH_ZERO;
          if (fld == FLD_POS && (b < CH_ZERO || b > CH_NINE)) flag_error(ERR_POS_DIGIT);
          else if (fld == FLD_POS && acc > 36'h7FFF_FFFF) flag_error(ERR_POS_OVF);
          else if (fld == FLD_ALT && model_dosage && b == CH_COMMA) flag_error(ERR_MULTI_ALT);
          else if (fld == FLD_FORMAT && (flen >= 2'd2 || b != (flen == 2'd0 ? CH_G : CH_T)))
            flag_error(ERR_NOT_GT);
          else begin
            if (fld == FLD_POS) pos_acc = acc[30:0];
            if (flen != 2'd3) flen = flen + 2'd1;
            if (eod) flag_error(ERR_FEW_FIELDS);
          end
        end
      end
      ST_CALLS: begin
        case (bis)
          2'd0: begin
            a = allele_of(b);
            if (a == -2) flag_error(ERR_BAD_ALLELE);
            else if (eod) flag_error(ERR_TRUNCATED);
            else begin
              held_a = a[4:0];
              bis = 2'd1;
            end
          end
          2'd1: begin
            if (b != CH_PIPE && b != CH_SLASH) flag_error(ERR_SEPARATOR);
            else if (b == CH_SLASH && !model_dosage) flag_error(ERR_UNPHASED);
            else if (eod) flag_error(ERR_TRUNCATED);
            else begin
              held_ph = (b == CH_PIPE);
              bis = 2'd2;
            end
          end
          2'd2: begin
            a = allele_of(b);
            if (a == -2) flag_error(ERR_BAD_ALLELE);
            else if (closes) begin
              take_call(a, 1'b1);
              st = ST_AFTER_CALLS;
            end else if (eod) flag_error(ERR_TRUNCATED);
            else begin
              take_call(a, 1'b0);
              bis = 2'd3;
            end
          end
          default: begin
            if (b != CH_TAB) flag_error(ERR_SEPARATOR);
            else if (eod) flag_error(ERR_TRUNCATED);
            else begin
              smp = smp + 16'd1;
              bis = 2'd0;
            end
          end
        endcase
      end
      ST_AFTER_CALLS: begin
        if (b == CH_CR) st = ST_AWAIT_LF;
        else if (b == CH_LF) st = ST_BETWEEN;
        else flag_error(ERR_SEPARATOR);
      end
      ST_AWAIT_LF: begin
        if (b == CH_LF) st = ST_BETWEEN;
        else flag_error(ERR_SEPARATOR);
      end
      default: ;
    endcase
    if (eod && !err_seen) st = ST_BETWEEN;
  endfunction

  function automatic string describe_call(vgrd_result_t r);
    return $sformatf("kind %0d pos %0d smp %0d a1 %0d a2 %0d dos %0d ph %0d last %0d err %0d",
                     r.kind, r.record_position, r.sample_number, r.first_allele,
                     r.second_allele, r.allele_dosage, r.is_phased, r.last_in_record,
                     r.error_code);
  endfunction

  // shadow update and result check on every edge
  always @(posedge clk_i) begin : monitor
    vgrd_result_t got;
    vgrd_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SAMPLE_COUNT) model_count = cfg_data_i;
        else model_dosage = cfg_data_i[0];
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind            = kind_e'(m_axis_tuser);
        got.record_position = m_axis_tdata[30:0];
        got.sample_number   = m_axis_tdata[46:31];
        got.first_allele    = m_axis_tdata[51:47];
        got.second_allele   = m_axis_tdata[56:52];
        got.allele_dosage   = m_axis_tdata[62:57];
        got.is_phased       = m_axis_tdata[63];
        got.last_in_record  = m_axis_tlast;
        got.error_code      = err_code_e'(m_axis_tdata[67:64]);
        if (decoded_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: %s", describe_call(got));
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected %s", describe_call(want));
              $display("          actual   %s", describe_call(got));
            end
          end
        end
      end
    end
  end

  // result side: random short stalls, or one long hold when requested
  initial begin : sink
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
        m_axis_tready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eod;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i][7:0], line_q[i][8]);
    line_q.delete();
  endtask

  task automatic send_text(input string s, input int eod_at);
    for (int i = 0; i < s.len(); i++) line_q.push_back({i == eod_at, s[i]});
    send_line();
  endtask

  // stop offering bytes, wait for every expected beat, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [15:0] count, input logic dosage);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SAMPLE_COUNT;
    cfg_data_i  <= count;
    @(posedge clk_i);
    cfg_index_i <= CFG_DOSAGE_MODE;
    cfg_data_i  <= {15'd0, dosage};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [7:0] text_byte(bit no_comma);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_TAB || b == CH_LF || b == CH_CR || (no_comma && b == CH_COMMA))
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // one well-formed record into line_q; end_style picks the line ending
  function automatic void build_record(int unsigned n, bit dosage, int end_style);
    string       digits;
    string       allele_chars;
    int unsigned v;
    logic [8:0]  tail;
    allele_chars = "0123456789.-";
    repeat ($urandom_range(0, 2))
      line_q.push_back({1'b0, ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF});
    for (int f = 0; f < 8; f++) begin
      if (f == 1) begin
        case ($urandom_range(0, 3))
          0: v = $urandom_range(0, 999);
          1: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
          default: v = $urandom & 32'h7FFF_FFFF;
        endcase
        if ($urandom_range(0, 4) == 0) line_q.push_back({1'b0, CH_ZERO});
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++) line_q.push_back({1'b0, digits[i]});
      end else begin
        repeat ($urandom_range(0, 3))
          line_q.push_back({1'b0, text_byte(f == 4 && dosage)});
        // commas in ALT are legal in phased mode
        if (f == 4 && !dosage && $urandom_range(0, 1) != 0)
          line_q.push_back({1'b0, CH_COMMA});
      end
      line_q.push_back({1'b0, CH_TAB});
    end
    line_q.push_back({1'b0, CH_G});
    line_q.push_back({1'b0, CH_T});
    line_q.push_back({1'b0, CH_TAB});
    for (int unsigned s = 0; s < n; s++) begin
      if (s != 0) line_q.push_back({1'b0, CH_TAB});
      line_q.push_back({1'b0, allele_chars[$urandom_range(0, 11)]});
      line_q.push_back({1'b0, (!dosage || $urandom_range(0, 1) != 0) ? CH_PIPE : CH_SLASH});
      line_q.push_back({1'b0, allele_chars[$urandom_range(0, 11)]});
    end
    if (end_style == 1 || end_style == 3 || end_style == 5) line_q.push_back({1'b0, CH_CR});
    if (end_style == 0 || end_style == 1 || end_style == 4 || end_style == 5)
      line_q.push_back({1'b0, CH_LF});
    // styles 2..5 mark the last byte as end of data
    if (end_style >= 2) begin
      tail = line_q.pop_back();
      line_q.push_back({1'b1, tail[7:0]});
    end
  endfunction

  task automatic test_reset_defaults();
    idling_on = 1'b1;
    // reset config: one sample, dosage mode, so '/' is legal
    send_text("\t2147483647\t\t\t\t\t\t\tGT\t9/-\n", -1);
  endtask

  task automatic test_config_extremes();
    string s;
    drain();
    write_config(16'd0, 1'b0);
    s = "\t0\t\t\t,\t\t\t\tGT\t.|0";
    send_text(s, s.len() - 1);
    drain();
    write_config(16'd3, 1'b1);
    send_text("\r\n\t007\tA\tB\tC\t\t\t\tGT\t0/9\t-|.\t5/5\r\n", -1);
  endtask

  task automatic test_output_backpressure();
    drain();
    write_config(16'd4, 1'b1);
    idling_on = 1'b0;
    hold_off_cycles = 300;
    repeat (4) begin
      build_record(4, 1'b1, $urandom_range(0, 1));
      send_line();
    end
  endtask

  task automatic test_random_records();
    int          stop_at;
    logic [15:0] count;
    bit          dosage;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      drain();
      case ($urandom_range(0, 9))
        0: count = 16'd0;
        1: count = 16'($urandom_range(7, 12));
        default: count = 16'($urandom_range(1, 4));
      endcase
      dosage = 1'($urandom_range(0, 1));
      write_config(count, dosage);
      idling_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 5)) begin
        build_record((count == 16'd0) ? 1 : count, dosage, $urandom_range(0, 5));
        send_line();
      end
    end
  endtask

  // widest count: calls run on without closing, then the count shrinks
  // between calls so the held-back call closes the record
  task automatic test_widest_record();
    bit         dosage;
    logic [8:0] tail_q[$];
    drain();
    idling_on = 1'b0;
    dosage = 1'($urandom_range(0, 1));
    write_config(16'hFFFF, dosage);
    build_record(12, dosage, 0);
    repeat (4) tail_q.push_front(line_q.pop_back());
    send_line();
    drain();
    write_config(16'd12, dosage);
    line_q = tail_q;
    send_line();
  endtask

  // errors latch until reset, so each run ends on one randomly chosen fault
  task automatic test_sticky_error();
    string hdr;
    string s;
    int    eod_at;
    int    pick;
    bit    dosage;
    hdr = "1\t100\tid\tA\tC\t50\tPASS\t.\t";
    pick = $urandom_range(0, 15);
    dosage = 1'($urandom_range(0, 1));
    eod_at = -1;
    case (pick)
      0: s = "1\t100\r";
      1: begin s = "1\t100\tid\tA"; eod_at = s.len() - 1; end
      2: s = {hdr, "GA\t0|1\n"};
      3: s = {hdr, "G\t0|1\n"};
      4: s = {hdr, "GTT\t0|1\n"};
      5: s = "1\t\tid\t";
      6: begin s = "1\t12x\t"; eod_at = 4; end   // content error beats end of data
      7: s = "1\t2147483648\t";
      8: begin s = "1\t5\tid\tA\tC,G\t"; dosage = 1'b1; end
      9: begin s = {hdr, "GT\t"}; eod_at = s.len() - 1; end
      10: begin s = {hdr, "GT\t0|"}; eod_at = s.len() - 1; end
      11: s = {hdr, "GT\t0x1\n"};
      12: s = {hdr, "GT\t0|1x"};
      13: s = {hdr, "GT\t0|1\rx"};
      14: s = {hdr, "GT\tz|1\n"};
      default: begin s = {hdr, "GT\t0/1\n"}; dosage = 1'b0; end
    endcase
    drain();
    write_config(16'd1, dosage);
    send_text(s, eod_at);
    // everything after the error must be swallowed
    send_text({"\n", hdr, "GT\t1|1\n"}, -1);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_config_extremes();
    test_output_backpressure();
    test_random_records();
    test_widest_record();
    test_sticky_error();
    drain();
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vgrd_pkg.sv
hw/rtl/vgrd_parser.sv
hw/rtl/vgrd_out_stage.sv
hw/rtl/vcf_gt_record_decoder_top.sv
bench/testbench.sv
